// ===== src/pbc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the potentiometer brightness conditioner.
package pbc_pkg;

	// Full-scale converter code, also the brightness ceiling and squaring divisor.
	localparam int ADC_FULL_SCALE = 1023;

	// Fixed field widths.
	localparam int SAMPLE_W    = 10;
	localparam int OFFSET_W    = 10;
	localparam int IN_GAIN_W   = 17;
	localparam int FILT_GAIN_W = 16;
	localparam int FRAC_W      = 16;
	localparam int BRIGHT_W    = 10;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 4;
	localparam int REG_IDX_W   = 2;

	// Widths that follow from the full-scale value.
	localparam int FS_W = $clog2(ADC_FULL_SCALE + 1);
	localparam int F_W  = FS_W + FRAC_W;
	localparam int X_W  = 2 * FS_W;
	localparam int R_W  = ((FS_W > SAMPLE_W) ? FS_W : SAMPLE_W) + 2;

	// Reciprocal of the full scale for the squaring divide.
	localparam int          RECIP_SHIFT = X_W;
	localparam longint      RECIP_K     = (longint'(1) << RECIP_SHIFT) / ADC_FULL_SCALE;
	localparam int          K_W         = $clog2(RECIP_K + 1);

	// Shared multiplier operand widths.
	localparam int MA_W  = (F_W > X_W) ? F_W : X_W;
	localparam int MB_T  = (IN_GAIN_W > K_W) ? IN_GAIN_W : K_W;
	localparam int MB_W  = (MB_T > FS_W) ? MB_T : FS_W;
	localparam int PRD_W = MA_W + MB_W;

	// Register reset values.
	localparam logic [OFFSET_W-1:0]    OFFSET_RST    = OFFSET_W'(29);
	localparam logic [IN_GAIN_W-1:0]   IN_GAIN_RST   = IN_GAIN_W'(69468);
	localparam logic [FILT_GAIN_W-1:0] FILT_GAIN_RST = FILT_GAIN_W'(655);
	localparam logic [F_W-1:0]         FILT_RST      = F_W'(128) << FRAC_W;
	localparam logic [FS_W-1:0]        FULL_SCALE    = FS_W'(ADC_FULL_SCALE);

	// Register indexes on the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_ADC_OFFSET  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INPUT_GAIN  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_GAIN = 2'd2;

	typedef struct packed {
		logic [OFFSET_W-1:0]    adc_offset;
		logic [IN_GAIN_W-1:0]   input_gain;
		logic [FILT_GAIN_W-1:0] filter_gain;
	} cfg_t;

endpackage

// ===== src/pbc_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module pbc_cfg
	import pbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [OFFSET_W-1:0]    offset_q;
	logic [IN_GAIN_W-1:0]   in_gain_q;
	logic [FILT_GAIN_W-1:0] filt_gain_q;
	logic [REG_IDX_W-1:0]   idx;
	logic                   wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= OFFSET_RST;
			in_gain_q   <= IN_GAIN_RST;
			filt_gain_q <= FILT_GAIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ADC_OFFSET:  offset_q    <= pwdata[OFFSET_W-1:0];
				REG_INPUT_GAIN:  in_gain_q   <= pwdata[IN_GAIN_W-1:0];
				REG_FILTER_GAIN: filt_gain_q <= pwdata[FILT_GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ADC_OFFSET:  prdata = APB_DATA_W'(offset_q);
			REG_INPUT_GAIN:  prdata = APB_DATA_W'(in_gain_q);
			REG_FILTER_GAIN: prdata = APB_DATA_W'(filt_gain_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.adc_offset  = offset_q;
	assign cfg.input_gain  = in_gain_q;
	assign cfg.filter_gain = filt_gain_q;

endmodule

// ===== src/pbc_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned multiplier used by every multiply step of the sequencer.
module pbc_mul
	import pbc_pkg::*;
(
	input  logic [MA_W-1:0]  op_a,
	input  logic [MB_W-1:0]  op_b,
	output logic [PRD_W-1:0] prod
);

	assign prod = PRD_W'(op_a) * PRD_W'(op_b);

endmodule

// ===== src/pbc_core.sv =====
`timescale 1ns / 1ps
// Sequencer and datapath registers: reading, filter, deadband, squaring and output stage.
module pbc_core
	import pbc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_W-1:0]    in_sample,
	input  logic                   in_level,
	input  logic                   in_fade,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_READ  = 4'd1;
	localparam logic [3:0] ST_DIFF  = 4'd2;
	localparam logic [3:0] ST_FMUL  = 4'd3;
	localparam logic [3:0] ST_FUPD  = 4'd4;
	localparam logic [3:0] ST_DIST  = 4'd5;
	localparam logic [3:0] ST_SQR   = 4'd6;
	localparam logic [3:0] ST_RECIP = 4'd7;
	localparam logic [3:0] ST_CORR  = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0]              state_q;
	logic signed [R_W-1:0]   r_q;
	logic [FS_W-1:0]         p_q;
	logic [F_W-1:0]          f_q;
	logic [F_W-1:0]          d_q;
	logic [F_W-1:0]          corr_q;
	logic                    above_q;
	logic [X_W-1:0]          x_q;
	logic [FS_W-1:0]         quo_q;
	logic [FS_W-1:0]         bright_q;
	logic                    changed_q;
	logic                    press_q;
	logic                    held_q;
	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;

	logic                    in_acc;
	logic                    out_load;
	logic signed [R_W-1:0]   r_next;
	logic [MA_W-1:0]         op_a;
	logic [MB_W-1:0]         op_b;
	logic [PRD_W-1:0]        prod;
	logic [PRD_W-FRAC_W-1:0] p_full;
	logic [F_W-1:0]          p16;
	logic [F_W-1:0]          gap;
	logic [X_W-1:0]          rem;

	pbc_mul u_mul (
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign r_next = $signed(R_W'(ADC_FULL_SCALE)) - $signed(R_W'(in_sample))
		- $signed(R_W'(cfg.adc_offset));
	assign p_full = prod[PRD_W-1:FRAC_W];
	assign p16    = {p_q, {FRAC_W{1'b0}}};
	assign gap    = (f_q >= p16) ? (f_q - p16) : (p16 - f_q);
	assign rem    = x_q - prod[X_W-1:0];

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_READ: begin
				op_a = MA_W'(r_q[FS_W-1:0]);
				op_b = MB_W'(cfg.input_gain);
			end
			ST_FMUL: begin
				op_a = MA_W'(d_q);
				op_b = MB_W'(cfg.filter_gain);
			end
			ST_SQR: begin
				op_a = MA_W'(p_q);
				op_b = MB_W'(p_q);
			end
			ST_RECIP: begin
				op_a = MA_W'(x_q);
				op_b = MB_W'(RECIP_K);
			end
			ST_CORR: begin
				op_a = MA_W'(quo_q);
				op_b = MB_W'(ADC_FULL_SCALE);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			f_q       <= FILT_RST;
			bright_q  <= FULL_SCALE;
			held_q    <= 1'b0;
			press_q   <= 1'b0;
			changed_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						r_q       <= r_next;
						press_q   <= !in_level && !held_q;
						held_q    <= !in_level;
						changed_q <= 1'b0;
						state_q   <= in_fade ? ST_DONE : ST_READ;
					end
				end
				ST_READ: begin
					if (r_q[R_W-1] || (r_q == '0)) begin
						p_q <= '0;
					end else if (p_full > (PRD_W-FRAC_W)'(ADC_FULL_SCALE)) begin
						p_q <= FULL_SCALE;
					end else begin
						p_q <= p_full[FS_W-1:0];
					end
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					above_q <= (f_q >= p16);
					d_q     <= gap;
					state_q <= ST_FMUL;
				end
				ST_FMUL: begin
					corr_q  <= p_full[F_W-1:0];
					state_q <= ST_FUPD;
				end
				ST_FUPD: begin
					f_q     <= above_q ? (f_q - corr_q) : (f_q + corr_q);
					state_q <= ST_DIST;
				end
				ST_DIST: begin
					if (gap[F_W-1:FRAC_W] != '0) begin
						changed_q <= 1'b1;
						state_q   <= ST_SQR;
					end else begin
						state_q   <= ST_DONE;
					end
				end
				ST_SQR: begin
					x_q     <= prod[X_W-1:0];
					state_q <= ST_RECIP;
				end
				ST_RECIP: begin
					quo_q   <= prod[RECIP_SHIFT+FS_W-1:RECIP_SHIFT];
					state_q <= ST_CORR;
				end
				ST_CORR: begin
					// The reciprocal estimate is at most one below the true quotient.
					bright_q <= (rem >= X_W'(ADC_FULL_SCALE)) ? (quo_q + 1'b1) : quo_q;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: holds a finished result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= OUT_TDATA_W'({press_q, changed_q, BRIGHT_W'(bright_q)});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_fade_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_fade) |=> (state_q == ST_DONE))
		else $error("fade tick did not bypass the filter");

	a_held_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (held_q == !$past(in_level)))
		else $error("button hold state does not follow the pin level");

	a_filt_range: assert property (@(posedge clk) disable iff (!arst_n)
		f_q <= (F_W'(ADC_FULL_SCALE) << FRAC_W))
		else $error("filter state above full scale");

	a_quo_corr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORR) |-> (rem < (X_W'(ADC_FULL_SCALE) << 1)))
		else $error("reciprocal quotient estimate off by more than one");

	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		bright_q <= FULL_SCALE)
		else $error("brightness above full scale");

endmodule

// ===== src/potentiometer_brightness_conditioner_top.sv =====
`timescale 1ns / 1ps
// Top level of the potentiometer brightness conditioner.
//
// One tick enters on the slave stream: s_tdata carries the converter sample,
// the button pin level (low means pressed) and the fade-active flag. One
// result leaves on the master stream per tick: the brightness level, a flag
// that the brightness was just taken from the reading, and a press event.
// The user must write gains and the offset over the APB-style port only while
// the block is idle; the block does not enforce it. pready is always high and
// reads return the register values. A single multiplier is shared by the
// sequencer for the reading gain, the filter correction, the squaring and the
// divide by full scale (reciprocal multiply plus a one-step correction).
// A fade tick goes straight to the done state; other ticks pass the read,
// filter and deadband steps, and squaring and divide follow when brightness
// is recomputed. A new tick is taken the cycle after the result is loaded.
// Reset restores the register defaults, sets the filter to 128 and the
// brightness to full scale, and clears the button state. When the receiver
// stalls, the result waits in the output register; a following tick is still
// taken and worked, and the block then waits until the register frees.
module potentiometer_brightness_conditioner_top
	import pbc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Slave stream. s_tdata from bit 0: adc_sample[9:0], button_level, fade_active.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// Master stream. m_tdata from bit 0: brightness[9:0], brightness_changed, press_event.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	cfg_t cfg;

	// Register file; the user keeps its outputs stable while a tick is in flight (not enforced).
	pbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer, datapath and output register.
	pbc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata[SAMPLE_W-1:0]),
		.in_level  (s_tdata[SAMPLE_W]),
		.in_fade   (s_tdata[SAMPLE_W+1]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// ===== sim/tb_potentiometer_brightness_conditioner_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the potentiometer brightness conditioner top level.
import pbc_pkg::*;

typedef longint unsigned u64_t;

// One expected result, laid out like the low bits of m_tdata.
typedef struct packed {
	logic                press_event;
	logic                brightness_changed;
	logic [BRIGHT_W-1:0] brightness;
} tick_out_t;

// Tracks registers and filter state, and holds the results owed by the block.
class brightness_tracker;
	logic [OFFSET_W-1:0]    offset;
	logic [IN_GAIN_W-1:0]   in_gain;
	logic [FILT_GAIN_W-1:0] filt_gain;
	u64_t                   filt_q16;
	u64_t                   bright_lvl;
	bit                     held;
	tick_out_t              pending_outputs[$];
	int unsigned            mismatches;
	int unsigned            ticks, changes, presses, frozen;

	function new();
		offset     = OFFSET_RST;
		in_gain    = IN_GAIN_RST;
		filt_gain  = FILT_GAIN_RST;
		filt_q16   = u64_t'(FILT_RST);
		bright_lvl = ADC_FULL_SCALE;
		held       = 1'b0;
	endfunction

	function void write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
		case (idx)
			REG_ADC_OFFSET:  offset    = value[OFFSET_W-1:0];
			REG_INPUT_GAIN:  in_gain   = value[IN_GAIN_W-1:0];
			REG_FILTER_GAIN: filt_gain = value[FILT_GAIN_W-1:0];
			default: ;
		endcase
	endfunction

	function logic [APB_DATA_W-1:0] register_value(logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_ADC_OFFSET:  return APB_DATA_W'(offset);
			REG_INPUT_GAIN:  return APB_DATA_W'(in_gain);
			REG_FILTER_GAIN: return APB_DATA_W'(filt_gain);
			default:         return '0;
		endcase
	endfunction

	// Inverted, offset and gained sample, clamped to the converter range.
	function u64_t pot_reading(logic [SAMPLE_W-1:0] sample);
		longint span;
		u64_t   scaled;
		span = longint'(ADC_FULL_SCALE) - longint'(sample) - longint'(offset);
		if (span <= 0)
			return 0;
		scaled = (u64_t'(span) * u64_t'(in_gain)) >> FRAC_W;
		if (scaled > u64_t'(ADC_FULL_SCALE))
			scaled = ADC_FULL_SCALE;
		return scaled;
	endfunction

	function void take_tick(logic [SAMPLE_W-1:0] sample, logic level, logic fade);
		tick_out_t want;
		u64_t      lvl, lvl_q16, gap;
		want = '0;
		ticks++;
		if (fade) begin
			frozen++;
		end else begin
			lvl     = pot_reading(sample);
			lvl_q16 = lvl << FRAC_W;
			// The correction is truncated in magnitude, so the filter never overshoots.
			if (filt_q16 >= lvl_q16)
				filt_q16 = filt_q16 - ((u64_t'(filt_gain) * (filt_q16 - lvl_q16)) >> FRAC_W);
			else
				filt_q16 = filt_q16 + ((u64_t'(filt_gain) * (lvl_q16 - filt_q16)) >> FRAC_W);
			gap = (filt_q16 >= lvl_q16) ? filt_q16 - lvl_q16 : lvl_q16 - filt_q16;
			if (gap >= (u64_t'(1) << FRAC_W)) begin
				bright_lvl = (lvl * lvl) / u64_t'(ADC_FULL_SCALE);
				want.brightness_changed = 1'b1;
				changes++;
			end
		end
		if (!level && !held) begin
			want.press_event = 1'b1;
			held = 1'b1;
			presses++;
		end else if (level && held) begin
			held = 1'b0;
		end
		want.brightness = bright_lvl[BRIGHT_W-1:0];
		pending_outputs.push_back(want);
	endfunction

	function void note_mismatch(string what, u64_t want, u64_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s differs: expected %0d, got %0d", $time, what, want, got);
	endfunction

	function void check_output(logic [OUT_TDATA_W-1:0] data);
		tick_out_t got, want;
		got = data[$bits(tick_out_t)-1:0];
		if (data[OUT_TDATA_W-1:$bits(tick_out_t)] != '0)
			note_mismatch("m_tdata padding", 0, data >> $bits(tick_out_t));
		if (pending_outputs.size() == 0) begin
			note_mismatch("unrequested result", 0, data);
			return;
		end
		want = pending_outputs.pop_front();
		if (got.brightness != want.brightness)
			note_mismatch("brightness", want.brightness, got.brightness);
		if (got.brightness_changed != want.brightness_changed)
			note_mismatch("brightness_changed", want.brightness_changed, got.brightness_changed);
		if (got.press_event != want.press_event)
			note_mismatch("press_event", want.press_event, got.press_event);
	endfunction
endclass

module tb_potentiometer_brightness_conditioner_top;

	// Index 3 has no register behind it; writes there must change nothing.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// A tick's work is brief, and stalls and gaps are random runs at
	// 64 percent at worst, so a long quiet stretch is already rare. A stretch
	// of QUIET_LIMIT quiet cycles can only mean the block has hung.
	localparam int unsigned QUIET_LIMIT = 2000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// s_tdata from bit 0: adc_sample[9:0], button_level, fade_active.
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// m_tdata from bit 0: brightness[9:0], brightness_changed, press_event.
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	brightness_tracker tracker;
	int unsigned       sender_idle_pct    = 0;
	int unsigned       receiver_stall_pct = 0;
	int unsigned       quiet_cycles       = 0;
	int unsigned       settings_used      = 0;

	potentiometer_brightness_conditioner_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver drops tready at random, at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Every transfer is sampled at the clock edge that completes it. Results
	// are checked before the new tick is noted, so a result can never be
	// matched against the tick that is entering in the same cycle. The same
	// block keeps the watchdog: it counts cycles with no transfer on either
	// stream and no register access.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check_output(m_tdata);
			if (s_tvalid && s_tready)
				tracker.take_tick(s_tdata[SAMPLE_W-1:0], s_tdata[SAMPLE_W], s_tdata[SAMPLE_W+1]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: watchdog expired, %0d results outstanding", $time,
						tracker.pending_outputs.size());
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	// Offers one tick and returns at the edge of its transfer. tvalid stays
	// high afterwards, so back-to-back ticks go out without a bubble unless
	// the sender decides to idle first.
	task automatic send_tick(logic [SAMPLE_W-1:0] sample, logic level, logic fade);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({fade, level, sample});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Holds the sender back until every owed result has come out. The first
	// edge lets the monitor note a tick that transferred in the calling cycle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_outputs.size() != 0)
			@(posedge clk);
	endtask

	// Writes a register (setup then access), then, except at the spare index,
	// reads it back in a second transfer that reuses the selected bus.
	task automatic program_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tracker.write_register(idx, value);
		if (idx != REG_SPARE) begin
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			readback = prdata;
			if (readback != tracker.register_value(idx))
				tracker.note_mismatch("register readback", tracker.register_value(idx), readback);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(logic [APB_DATA_W-1:0] offset, logic [APB_DATA_W-1:0] in_gain,
			logic [APB_DATA_W-1:0] filt_gain);
		program_register(REG_ADC_OFFSET, offset);
		program_register(REG_INPUT_GAIN, in_gain);
		program_register(REG_FILTER_GAIN, filt_gain);
		settings_used++;
	endtask

	function automatic int clamp_code(int code);
		return (code < 0) ? 0 : (code > ADC_FULL_SCALE) ? ADC_FULL_SCALE : code;
	endfunction

	// Random ticks shaped like a real knob: the sample dwells near a target for
	// a while (so the filter can settle into the deadband), then jumps close by,
	// anywhere, to a range edge or to the knee. A little jitter and some one-off
	// noise samples are mixed in. The button and the fade flag run in stretches
	// so that presses, holds and releases all occur inside and outside fades.
	task automatic run_random(int unsigned count);
		int   target;
		int   samp;
		int   dwell;
		int   knee;
		logic level;
		logic fade;
		target = $urandom_range(ADC_FULL_SCALE);
		dwell  = 0;
		level  = 1'b1;
		fade   = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (dwell == 0) begin
				dwell = $urandom_range(40, 1);
				knee  = ADC_FULL_SCALE - int'(tracker.offset);
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
						target = target + int'($urandom_range(32)) - 16;
					17: target = 0;
					18: target = ADC_FULL_SCALE;
					19: target = knee + int'($urandom_range(2)) - 1;
					default: target = $urandom_range(ADC_FULL_SCALE);
				endcase
				target = clamp_code(target);
			end
			dwell--;
			samp = target;
			if ($urandom_range(3) == 0)
				samp = clamp_code(target + int'($urandom_range(2)) - 1);
			if ($urandom_range(99) < 5)
				samp = $urandom_range(ADC_FULL_SCALE);
			if ($urandom_range(99) < 12)
				level = ~level;
			if (fade ? ($urandom_range(99) < 25) : ($urandom_range(99) < 5))
				fade = ~fade;
			send_tick(samp[SAMPLE_W-1:0], level, fade);
		end
	endtask

	initial begin
		tracker = new();
		arst_n  <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks on the reset settings: full-scale and zero samples,
		// the sample right at the offset knee and one code past it, fades with
		// the button pressed and held, a release and a second press.
		send_tick(10'd0, 1'b1, 1'b0);
		send_tick(10'd1023, 1'b1, 1'b0);
		send_tick(10'd994, 1'b1, 1'b0);
		send_tick(10'd993, 1'b1, 1'b0);
		send_tick(10'd512, 1'b1, 1'b1);
		send_tick(10'd0, 1'b0, 1'b1);
		send_tick(10'd0, 1'b0, 1'b0);
		send_tick(10'd0, 1'b0, 1'b0);
		send_tick(10'd300, 1'b1, 1'b0);
		send_tick(10'd300, 1'b0, 1'b1);
		send_tick(10'd1023, 1'b1, 1'b1);
		send_tick(10'd1, 1'b1, 1'b0);
		wait_drained();

		// With the fastest filter a steady sample settles inside the deadband
		// at once, so repeats must leave brightness alone. A write to the
		// unused index must not disturb any register.
		program_register(REG_FILTER_GAIN, 32'hFFFF_FFFF);
		program_register(REG_SPARE, $urandom());
		send_tick(10'd500, 1'b1, 1'b0);
		send_tick(10'd500, 1'b1, 1'b0);
		send_tick(10'd500, 1'b1, 1'b0);
		send_tick(10'd501, 1'b1, 1'b0);
		send_tick(10'd500, 1'b0, 1'b0);
		send_tick(10'd10, 1'b1, 1'b0);
		wait_drained();

		// Random phases. Each one starts from a drained block with a new
		// register setting; the idle pattern cycles through no idling, a slow
		// sender, a slow receiver, and both at a moderate rate.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: apply_setting(32'd29, 32'd69468, 32'd655);
				// Upper bits set: each register should keep only its own width.
				1: apply_setting(32'hFFFF_FC00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: apply_setting(32'd1023, 32'd0, 32'd0);
				3: apply_setting($urandom_range(ADC_FULL_SCALE), $urandom_range(131071),
					$urandom_range(65535));
				4: apply_setting(32'd0, 32'd65536, 32'd32768);
				5: apply_setting($urandom(), $urandom(), $urandom());
				6: apply_setting(32'd512, 32'd131071, 32'd1);
				default: apply_setting(32'd29, 32'd69468, 32'd655);
			endcase
			case (phase % 4)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct    = 64;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 64;
				end
				default: begin
					sender_idle_pct    = 24;
					receiver_stall_pct = 24;
				end
			endcase
			run_random(190);
			wait_drained();
		end

		// Let any stray result show up before judging the run.
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		repeat (20) @(posedge clk);
		if (tracker.pending_outputs.size() != 0)
			tracker.note_mismatch("results never delivered", tracker.pending_outputs.size(), 0);

		$display("Run covered %0d ticks under %0d register settings and four idle patterns.",
			tracker.ticks, settings_used);
		$display("It saw %0d brightness updates, %0d presses and %0d ticks during fades.",
			tracker.changes, tracker.presses, tracker.frozen);
		if (tracker.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches in total", tracker.mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
